/* src/rbst_pkg.sv */
// ----------------------------------------------------------------------------
// Ray box slab test package
// Shared widths, pipeline depth constants and the per-axis span type.
// ----------------------------------------------------------------------------
package rbst_pkg;

   localparam int Q_W        = 32;
   localparam int NUM_W      = 49;   // 33-bit offset magnitude scaled by 2^16
   localparam int DIV_STAGES = 32;   // one quotient bit per stage
   localparam int AXES       = 3;
   // Prep register, divider stages, clamp/order register, merge register.
   localparam int LATENCY    = DIV_STAGES + 3;

   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

   typedef struct packed {
      logic signed [Q_W-1:0] near_t;
      logic signed [Q_W-1:0] far_t;
   } span_type;

endpackage

/* src/ray_box_slab_test_top.sv */
// ----------------------------------------------------------------------------
// Ray box slab test, top level
// Fixed-point ray versus axis-aligned box test with three parallel slab lanes.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                          Beat accepted when
//   request   start, busy, req_*             start is high and busy is low
//   response  rsp_valid, rsp_*               rsp_valid is high (one cycle)
//
// A new ray and box may be started in every cycle; busy stays low.
// Each beat's result passes through a prep register, the 32-stage restoring
// divider in each lane, a clamp and order register and the merge register.
// Reset is synchronous and active high and clears only the valid pipeline.
// The receiver cannot stall, so results leave in the order the beats came in.
//
module ray_box_slab_test_top
   import rbst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic signed [Q_W-1:0] req_origin_x,
   input  logic signed [Q_W-1:0] req_origin_y,
   input  logic signed [Q_W-1:0] req_origin_z,
   input  logic signed [Q_W-1:0] req_dir_x,
   input  logic signed [Q_W-1:0] req_dir_y,
   input  logic signed [Q_W-1:0] req_dir_z,
   input  logic signed [Q_W-1:0] req_box_low_x,
   input  logic signed [Q_W-1:0] req_box_low_y,
   input  logic signed [Q_W-1:0] req_box_low_z,
   input  logic signed [Q_W-1:0] req_box_high_x,
   input  logic signed [Q_W-1:0] req_box_high_y,
   input  logic signed [Q_W-1:0] req_box_high_z,
   output logic                  rsp_valid,
   output logic                  rsp_hit,
   output logic signed [Q_W-1:0] rsp_t_entry,
   output logic signed [Q_W-1:0] rsp_t_exit
);

   // The datapath is a fixed-depth pipeline, so a beat is always welcome.
   assign busy = 1'b0;

   logic signed [Q_W-1:0] org [AXES];
   logic signed [Q_W-1:0] dir [AXES];
   logic signed [Q_W-1:0] lo  [AXES];
   logic signed [Q_W-1:0] hi  [AXES];
   span_type              spans [AXES];

   assign org[0] = req_origin_x;   assign org[1] = req_origin_y;   assign org[2] = req_origin_z;
   assign dir[0] = req_dir_x;      assign dir[1] = req_dir_y;      assign dir[2] = req_dir_z;
   assign lo[0]  = req_box_low_x;  assign lo[1]  = req_box_low_y;  assign lo[2]  = req_box_low_z;
   assign hi[0]  = req_box_high_x; assign hi[1]  = req_box_high_y; assign hi[2]  = req_box_high_z;

   // One lane per axis; each lane owns two dividers, one for each corner.
   genvar a;
   generate
      for (a = 0; a < AXES; a++) begin : g_lane
         rbst_lane u_lane (
            .clock(clock), .org(org[a]), .dir(dir[a]), .lo(lo[a]), .hi(hi[a]),
            .span(spans[a])
         );
      end
   endgenerate

   rbst_merge u_merge (
      .clock(clock), .spans(spans), .hit(rsp_hit), .t_entry(rsp_t_entry),
      .t_exit(rsp_t_exit)
   );

   // The valid bits walk beside the datapath; the payload needs no reset.
   logic [LATENCY-1:0] vld_ff, vld_in;

   always_comb begin
      vld_in = {vld_ff[LATENCY-2:0], start && !busy};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[LATENCY-1];

`ifndef SYNTHESIS
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised on a free-running pipeline");
   a_rsp_follows_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start, LATENCY))
      else $error("response without a matching request");
   a_hit_exit_ahead: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> !rsp_t_exit[Q_W-1])
      else $error("hit reported with a negative exit");
   a_hit_ordered: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |-> (rsp_t_entry <= rsp_t_exit))
      else $error("hit reported with entry after exit");
`endif

endmodule

/* src/rbst_div.sv */
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division of a 49-bit magnitude by a 32-bit magnitude, one quotient
// bit per stage. Sign and overflow flags travel alongside.
// ----------------------------------------------------------------------------
module rbst_div
   import rbst_pkg::*;
(
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [Q_W-1:0]   den,
   input  logic             neg,
   input  logic             ovf,
   output logic [Q_W-1:0]   quo,
   output logic             quo_neg,
   output logic             quo_ovf
);

   logic [Q_W-1:0] rem_ff [1:DIV_STAGES];
   logic [Q_W-1:0] low_ff [1:DIV_STAGES];
   logic [Q_W-1:0] quo_ff [1:DIV_STAGES];
   logic [Q_W-1:0] den_ff [1:DIV_STAGES];
   logic           neg_ff [1:DIV_STAGES];
   logic           ovf_ff [1:DIV_STAGES];

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_stage
         logic [Q_W-1:0] rem_src, low_src, quo_src, den_src;
         logic           neg_src, ovf_src;
         logic [Q_W:0]   trial;
         logic           ge;
         logic [Q_W-1:0] rem_in;

         if (k == 0) begin : g_first
            assign rem_src = {{(2*Q_W-NUM_W){1'b0}}, num[NUM_W-1:Q_W]};
            assign low_src = num[Q_W-1:0];
            assign quo_src = '0;
            assign den_src = den;
            assign neg_src = neg;
            assign ovf_src = ovf;
         end else begin : g_next
            assign rem_src = rem_ff[k];
            assign low_src = low_ff[k];
            assign quo_src = quo_ff[k];
            assign den_src = den_ff[k];
            assign neg_src = neg_ff[k];
            assign ovf_src = ovf_ff[k];
         end

         assign trial  = {rem_src, low_src[Q_W-1]};
         assign ge     = trial >= {1'b0, den_src};
         assign rem_in = ge ? Q_W'(trial - {1'b0, den_src}) : trial[Q_W-1:0];

         always_ff @(posedge clock) begin
            rem_ff[k+1] <= rem_in;
            low_ff[k+1] <= {low_src[Q_W-2:0], 1'b0};
            quo_ff[k+1] <= {quo_src[Q_W-2:0], ge};
            den_ff[k+1] <= den_src;
            neg_ff[k+1] <= neg_src;
            ovf_ff[k+1] <= ovf_src;
         end
      end
   endgenerate

   assign quo     = quo_ff[DIV_STAGES];
   assign quo_neg = neg_ff[DIV_STAGES];
   assign quo_ovf = ovf_ff[DIV_STAGES];

endmodule

/* src/rbst_lane.sv */
// ----------------------------------------------------------------------------
// Slab lane
// Computes the ordered entry and exit distances of one axis, with the zero
// direction cases handled beside the two dividers.
// ----------------------------------------------------------------------------
module rbst_lane
   import rbst_pkg::*;
(
   input  logic                  clock,
   input  logic signed [Q_W-1:0] org,
   input  logic signed [Q_W-1:0] dir,
   input  logic signed [Q_W-1:0] lo,
   input  logic signed [Q_W-1:0] hi,
   output span_type              span
);

   logic signed [Q_W:0] off_lo, off_hi;
   logic [Q_W:0]        mag_lo, mag_hi;
   logic [Q_W-1:0]      dmag;
   logic [NUM_W-1:0]    num_lo_in, num_hi_in;
   logic                inside_in;

   logic [NUM_W-1:0] num_lo_ff, num_hi_ff;
   logic [Q_W-1:0]   den_ff;
   logic             neg_lo_ff, neg_hi_ff, ovf_lo_ff, ovf_hi_ff;
   logic             dz_ff [0:DIV_STAGES];
   logic             inside_ff [0:DIV_STAGES];

   logic [Q_W-1:0] q_lo, q_hi;
   logic           qn_lo, qn_hi, qo_lo, qo_hi;
   logic signed [Q_W-1:0] t_a, t_b;
   span_type       span_in, span_ff;

   function automatic logic signed [Q_W-1:0] clamp_quo(
      input logic [Q_W-1:0] q, input logic n, input logic o);
      logic signed [Q_W-1:0] r;
      if (n) begin
         r = (o || (q > {1'b1, {(Q_W-1){1'b0}}})) ? Q_MIN : -$signed(q);
      end else begin
         r = (o || q[Q_W-1]) ? Q_MAX : $signed(q);
      end
      return r;
   endfunction

   always_comb begin
      off_lo    = {lo[Q_W-1], lo} - {org[Q_W-1], org};
      off_hi    = {hi[Q_W-1], hi} - {org[Q_W-1], org};
      mag_lo    = off_lo[Q_W] ? (Q_W+1)'(-off_lo) : off_lo;
      mag_hi    = off_hi[Q_W] ? (Q_W+1)'(-off_hi) : off_hi;
      dmag      = dir[Q_W-1] ? Q_W'(-dir) : dir;
      num_lo_in = {mag_lo, 16'b0};
      num_hi_in = {mag_hi, 16'b0};
      // The origin may sit between the corners in either order.
      inside_in = ((org >= lo) && (org <= hi)) || ((org >= hi) && (org <= lo));
   end

   always_ff @(posedge clock) begin
      num_lo_ff    <= num_lo_in;
      num_hi_ff    <= num_hi_in;
      den_ff       <= dmag;
      neg_lo_ff    <= off_lo[Q_W] ^ dir[Q_W-1];
      neg_hi_ff    <= off_hi[Q_W] ^ dir[Q_W-1];
      // A quotient of 2^32 or more saturates whatever its low bits are.
      ovf_lo_ff    <= {{(2*Q_W-NUM_W){1'b0}}, num_lo_in[NUM_W-1:Q_W]} >= dmag;
      ovf_hi_ff    <= {{(2*Q_W-NUM_W){1'b0}}, num_hi_in[NUM_W-1:Q_W]} >= dmag;
      dz_ff[0]     <= (dir == '0);
      inside_ff[0] <= inside_in;
   end

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_delay
         always_ff @(posedge clock) begin
            dz_ff[k+1]     <= dz_ff[k];
            inside_ff[k+1] <= inside_ff[k];
         end
      end
   endgenerate

   rbst_div u_div_lo (
      .clock(clock), .num(num_lo_ff), .den(den_ff), .neg(neg_lo_ff), .ovf(ovf_lo_ff),
      .quo(q_lo), .quo_neg(qn_lo), .quo_ovf(qo_lo)
   );

   rbst_div u_div_hi (
      .clock(clock), .num(num_hi_ff), .den(den_ff), .neg(neg_hi_ff), .ovf(ovf_hi_ff),
      .quo(q_hi), .quo_neg(qn_hi), .quo_ovf(qo_hi)
   );

   always_comb begin
      t_a = clamp_quo(q_lo, qn_lo, qo_lo);
      t_b = clamp_quo(q_hi, qn_hi, qo_hi);
      if (dz_ff[DIV_STAGES]) begin
         span_in.near_t = inside_ff[DIV_STAGES] ? Q_MIN : Q_MAX;
         span_in.far_t  = inside_ff[DIV_STAGES] ? Q_MAX : Q_MIN;
      end else if (t_b < t_a) begin
         span_in.near_t = t_b;
         span_in.far_t  = t_a;
      end else begin
         span_in.near_t = t_a;
         span_in.far_t  = t_b;
      end
   end

   always_ff @(posedge clock) begin
      span_ff <= span_in;
   end

   assign span = span_ff;

endmodule

/* src/rbst_merge.sv */
// ----------------------------------------------------------------------------
// Span merge
// Takes the latest entry and earliest exit of the three lanes and forms hit.
// ----------------------------------------------------------------------------
module rbst_merge
   import rbst_pkg::*;
(
   input  logic                  clock,
   input  span_type              spans [AXES],
   output logic                  hit,
   output logic signed [Q_W-1:0] t_entry,
   output logic signed [Q_W-1:0] t_exit
);

   logic signed [Q_W-1:0] entry_in, exit_in;
   logic signed [Q_W-1:0] entry_ff, exit_ff;
   logic                  hit_ff;

   always_comb begin
      entry_in = Q_MIN;
      exit_in  = Q_MAX;
      for (int i = 0; i < AXES; i++) begin
         if (spans[i].near_t > entry_in) entry_in = spans[i].near_t;
         if (spans[i].far_t  < exit_in)  exit_in  = spans[i].far_t;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      exit_ff  <= exit_in;
      hit_ff   <= (entry_in <= exit_in) && !exit_in[Q_W-1];
   end

   assign hit     = hit_ff;
   assign t_entry = entry_ff;
   assign t_exit  = exit_ff;

endmodule

/* bench/ray_box_slab_test_checker.sv */
// ----------------------------------------------------------------------------
// Ray box slab test checker
// Watches the request and response channels, predicts each hit and interval
// in fixed point and compares the response beats in order.
// ----------------------------------------------------------------------------
module ray_box_slab_test_checker
   import rbst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  busy,
   input  logic signed [Q_W-1:0] req_origin_x,
   input  logic signed [Q_W-1:0] req_origin_y,
   input  logic signed [Q_W-1:0] req_origin_z,
   input  logic signed [Q_W-1:0] req_dir_x,
   input  logic signed [Q_W-1:0] req_dir_y,
   input  logic signed [Q_W-1:0] req_dir_z,
   input  logic signed [Q_W-1:0] req_box_low_x,
   input  logic signed [Q_W-1:0] req_box_low_y,
   input  logic signed [Q_W-1:0] req_box_low_z,
   input  logic signed [Q_W-1:0] req_box_high_x,
   input  logic signed [Q_W-1:0] req_box_high_y,
   input  logic signed [Q_W-1:0] req_box_high_z,
   input  logic                  rsp_valid,
   input  logic                  rsp_hit,
   input  logic signed [Q_W-1:0] rsp_t_entry,
   input  logic signed [Q_W-1:0] rsp_t_exit,
   output int                    fail_count,
   output int                    pending_count,
   output int                    hit_count,
   output int                    result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic                  hit;
      logic signed [Q_W-1:0] t_entry;
      logic signed [Q_W-1:0] t_exit;
   } slab_result_type;

   slab_result_type expected_hits[$];

   function automatic logic signed [63:0] saturate_q(input logic signed [63:0] v);
      if (v > 64'(signed'(Q_MAX))) return 64'(signed'(Q_MAX));
      if (v < 64'(signed'(Q_MIN))) return 64'(signed'(Q_MIN));
      return v;
   endfunction

   function automatic span_type slab_span(input logic signed [Q_W-1:0] o,
                                          input logic signed [Q_W-1:0] d,
                                          input logic signed [Q_W-1:0] lo,
                                          input logic signed [Q_W-1:0] hi);
      logic signed [63:0] a, b, tmp, mn, mx;
      span_type s;
      if (d == 0) begin
         mn = (lo < hi) ? lo : hi;
         mx = (lo < hi) ? hi : lo;
         if (64'(o) >= mn && 64'(o) <= mx) begin
            s.near_t = Q_MIN;
            s.far_t  = Q_MAX;
         end else begin
            s.near_t = Q_MAX;
            s.far_t  = Q_MIN;
         end
         return s;
      end
      // SystemVerilog signed division truncates toward zero, as required.
      a = saturate_q(((64'(lo) - 64'(o)) * 64'sd65536) / 64'(d));
      b = saturate_q(((64'(hi) - 64'(o)) * 64'sd65536) / 64'(d));
      if (b < a) begin
         tmp = a;
         a = b;
         b = tmp;
      end
      s.near_t = a[Q_W-1:0];
      s.far_t  = b[Q_W-1:0];
      return s;
   endfunction

   function automatic slab_result_type predict_slab_hit();
      span_type sx, sy, sz;
      slab_result_type r;
      logic signed [Q_W-1:0] en, ex;
      sx = slab_span(req_origin_x, req_dir_x, req_box_low_x, req_box_high_x);
      sy = slab_span(req_origin_y, req_dir_y, req_box_low_y, req_box_high_y);
      sz = slab_span(req_origin_z, req_dir_z, req_box_low_z, req_box_high_z);
      en = sx.near_t;
      ex = sx.far_t;
      if (sy.near_t > en) en = sy.near_t;
      if (sz.near_t > en) en = sz.near_t;
      if (sy.far_t < ex) ex = sy.far_t;
      if (sz.far_t < ex) ex = sz.far_t;
      r.hit = (en <= ex) && (ex >= 0);
      r.t_entry = en;
      r.t_exit = ex;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      hit_count = 0;
      result_count = 0;
   end

   always @(posedge clock) begin
      slab_result_type want;
      if (!reset) begin
         if (start && !busy) expected_hits.push_back(predict_slab_hit());
         if (rsp_valid) begin
            result_count++;
            if (rsp_hit) hit_count++;
            if (expected_hits.size() == 0) begin
               report_mismatch("response beat with nothing expected");
            end else begin
               want = expected_hits.pop_front();
               if (rsp_hit !== want.hit)
                  report_mismatch($sformatf("hit got %0b want %0b", rsp_hit, want.hit));
               if (rsp_t_entry !== want.t_entry)
                  report_mismatch($sformatf("t_entry got %0d want %0d",
                                            rsp_t_entry, want.t_entry));
               if (rsp_t_exit !== want.t_exit)
                  report_mismatch($sformatf("t_exit got %0d want %0d",
                                            rsp_t_exit, want.t_exit));
            end
         end
      end
      pending_count = expected_hits.size();
   end
endmodule

/* bench/ray_box_slab_test_top_tb.sv */
// ----------------------------------------------------------------------------
// Ray box slab test bench
// Drives directed and random rays and boxes into the slab test and lets the
// checker compare every response beat against a fixed-point prediction.
// ----------------------------------------------------------------------------
module ray_box_slab_test_top_tb;
   import rbst_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BEATS = 1850;
   localparam int CYCLE_LIMIT  = 200000;

   logic clock, reset, start, busy;
   logic signed [Q_W-1:0] req_origin_x, req_origin_y, req_origin_z;
   logic signed [Q_W-1:0] req_dir_x, req_dir_y, req_dir_z;
   logic signed [Q_W-1:0] req_box_low_x, req_box_low_y, req_box_low_z;
   logic signed [Q_W-1:0] req_box_high_x, req_box_high_y, req_box_high_z;
   logic rsp_valid, rsp_hit;
   logic signed [Q_W-1:0] rsp_t_entry, rsp_t_exit;
   int fail_count, pending_count, hit_count, result_count;
   int cycle_count;

   ray_box_slab_test_top dut (.*);
   ray_box_slab_test_checker checker_inst (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // The run stops here if the block ever hangs.
   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
         end
      end
   end

   // One field value: mostly small coordinates so rays actually meet boxes,
   // sometimes full-range words and the two extremes.
   function automatic logic signed [Q_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return Q_MAX;
         2: return Q_MIN;
         3: return 0;
         default: return $signed($urandom_range(0, 32'h00200000)) - 32'sh00100000;
      endcase
   endfunction

   // Directions are zero now and then so the unbounded and empty slab cases
   // keep showing up in the random part.
   function automatic logic signed [Q_W-1:0] pick_dir();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return $urandom();
         2: return $signed($urandom_range(1, 4)) * (($urandom_range(0, 1)) ? 1 : -1);
         default: return $signed($urandom_range(0, 32'h00040000)) - 32'sh00020000;
      endcase
   endfunction

   // Present one beat and hold it until it is taken. Start stays high across
   // back-to-back beats; it is only lowered when an idle cycle follows.
   task automatic send_beat(input logic signed [Q_W-1:0] f[12], input bit may_idle);
      if (may_idle) begin
         while ($urandom_range(0, 99) < 23) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end
      start <= 1'b1;
      req_origin_x <= f[0];   req_origin_y <= f[1];   req_origin_z <= f[2];
      req_dir_x <= f[3];      req_dir_y <= f[4];      req_dir_z <= f[5];
      req_box_low_x <= f[6];  req_box_low_y <= f[7];  req_box_low_z <= f[8];
      req_box_high_x <= f[9]; req_box_high_y <= f[10]; req_box_high_z <= f[11];
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // A beat built around one axis pattern repeated on all three axes.
   task automatic send_uniform(input logic signed [Q_W-1:0] o, input logic signed [Q_W-1:0] d,
                               input logic signed [Q_W-1:0] lo,
                               input logic signed [Q_W-1:0] hi);
      logic signed [Q_W-1:0] f[12];
      for (int k = 0; k < 3; k++) begin
         f[k] = o; f[3+k] = d; f[6+k] = lo; f[9+k] = hi;
      end
      send_beat(f, 1'b0);
   endtask

   initial begin
      logic signed [Q_W-1:0] f[12];
      bit quiet;
      start = 0;
      reset = 1;
      {req_origin_x, req_origin_y, req_origin_z} = '0;
      {req_dir_x, req_dir_y, req_dir_z} = '0;
      {req_box_low_x, req_box_low_y, req_box_low_z} = '0;
      {req_box_high_x, req_box_high_y, req_box_high_z} = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: plain hit, miss behind the origin, swapped corners,
      // zero direction with the origin inside and outside the slab,
      // saturating quotients and the field extremes.
      send_uniform(0, 32'sh00010000, 32'sh00020000, 32'sh00040000);
      send_uniform(0, 32'sh00010000, -32'sh00040000, -32'sh00020000);
      send_uniform(0, -32'sh00010000, 32'sh00040000, 32'sh00020000);
      send_uniform(32'sh00010000, 0, 0, 32'sh00020000);
      send_uniform(32'sh00020000, 0, 32'sh00020000, 0);
      send_uniform(32'sh00050000, 0, 0, 32'sh00020000);
      send_uniform(0, 1, Q_MIN, Q_MAX);
      send_uniform(Q_MIN, 1, Q_MAX, Q_MAX);
      send_uniform(Q_MAX, -1, Q_MIN, Q_MIN);
      send_uniform(Q_MAX, Q_MIN, Q_MIN, Q_MAX);
      send_uniform(Q_MIN, Q_MAX, Q_MAX, Q_MIN);
      send_uniform(0, Q_MIN, Q_MIN, Q_MIN);
      send_uniform(-1, -1, -1, -1);
      send_uniform(32'sh0000ffff, 32'sh00000003, 32'sh7fff0000, 32'sh80010000);
      f = '{0, 0, 0, 32'sh00010000, 0, -32'sh00010000,
            32'sh00010000, -32'sh00010000, -32'sh00030000,
            32'sh00020000, 32'sh00010000, -32'sh00020000};
      send_beat(f, 1'b0);
      f = '{0, 0, 0, 32'sh00010000, 0, 0, 32'sh00010000, 32'sh00010000, 0,
            32'sh00020000, 32'sh00020000, 0};
      send_beat(f, 1'b0);
      start <= 1'b0;

      // Hold off until every directed result is back.
      while (pending_count != 0) @(posedge clock);

      // Random part; beats 600 to 899 go with no idle cycles at all.
      for (int n = 0; n < RANDOM_BEATS; n++) begin
         quiet = (n >= 600 && n < 900);
         for (int k = 0; k < 3; k++) begin
            f[k] = pick_coord();
            f[3+k] = pick_dir();
            f[6+k] = pick_coord();
            f[9+k] = pick_coord();
            // Often place the origin inside the slab so zero directions hit.
            if ($urandom_range(0, 3) == 0) f[k] = f[6+k];
         end
         send_beat(f, !quiet);
      end
      start <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);

      $display("covered %0d response beats, %0d of them hits, directed edge rays first",
               result_count, hit_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

/* filelist.f */
src/rbst_pkg.sv
src/rbst_div.sv
src/rbst_lane.sv
src/rbst_merge.sv
src/ray_box_slab_test_top.sv
bench/ray_box_slab_test_checker.sv
bench/ray_box_slab_test_top_tb.sv
